// ----- design/jtl_pkg.sv -----
`default_nettype none

package jtl_pkg;

   // result queue sizing
   localparam int MAX_RESULTS  = 3;
   localparam int QUEUE_DEPTH  = 4;
   localparam int COUNT_BITS   = 2;
   localparam int QCOUNT_BITS  = 3;
   localparam int QPTR_BITS    = 2;

   // lexer modes
   localparam logic [1:0] MODE_IDLE    = 2'd0;
   localparam logic [1:0] MODE_NUMBER  = 2'd1;
   localparam logic [1:0] MODE_STRING  = 2'd2;
   localparam logic [1:0] MODE_KEYWORD = 2'd3;

   // result kinds
   localparam logic [1:0] KIND_TOKEN = 2'd0;
   localparam logic [1:0] KIND_ERROR = 2'd1;
   localparam logic [1:0] KIND_DONE  = 2'd2;

   // token types
   localparam logic [3:0] TOK_LBRACE  = 4'd0;
   localparam logic [3:0] TOK_RBRACE  = 4'd1;
   localparam logic [3:0] TOK_LBRACK  = 4'd2;
   localparam logic [3:0] TOK_RBRACK  = 4'd3;
   localparam logic [3:0] TOK_INTEGER = 4'd4;
   localparam logic [3:0] TOK_REAL    = 4'd5;
   localparam logic [3:0] TOK_BOOLEAN = 4'd6;
   localparam logic [3:0] TOK_NULL    = 4'd7;
   localparam logic [3:0] TOK_STRING  = 4'd8;
   localparam logic [3:0] TOK_COLON   = 4'd9;
   localparam logic [3:0] TOK_COMMA   = 4'd10;
   localparam logic [3:0] TOK_NONE    = 4'd0;

   // error codes
   localparam logic [3:0] ERR_TWO_DOTS    = 4'd0;
   localparam logic [3:0] ERR_INNER_MINUS = 4'd1;
   localparam logic [3:0] ERR_BAD_NUMBER  = 4'd2;
   localparam logic [3:0] ERR_END_NUMBER  = 4'd3;
   localparam logic [3:0] ERR_END_KEYWORD = 4'd4;
   localparam logic [3:0] ERR_KW_MISMATCH = 4'd5;
   localparam logic [3:0] ERR_END_STRING  = 4'd6;
   localparam logic [3:0] ERR_STRAY       = 4'd7;
   localparam logic [3:0] ERR_TOO_LONG    = 4'd8;
   localparam logic [3:0] ERR_NONE        = 4'd0;

   // keyword selectors
   localparam logic [1:0] KW_TRUE  = 2'd0;
   localparam logic [1:0] KW_FALSE = 2'd1;
   localparam logic [1:0] KW_NULL  = 2'd2;

   // characters
   localparam logic [7:0] CHAR_LBRACE = 8'h7B;
   localparam logic [7:0] CHAR_RBRACE = 8'h7D;
   localparam logic [7:0] CHAR_LBRACK = 8'h5B;
   localparam logic [7:0] CHAR_RBRACK = 8'h5D;
   localparam logic [7:0] CHAR_COLON  = 8'h3A;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_DOT    = 8'h2E;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_NL     = 8'h0A;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_ZERO   = 8'd48;
   localparam logic [7:0] CHAR_COLONX = 8'd58;
   localparam logic [7:0] CHAR_T      = 8'h74;
   localparam logic [7:0] CHAR_F      = 8'h66;
   localparam logic [7:0] CHAR_N      = 8'h6E;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [3:0]  token_type;
      logic [15:0] start_position;
      logic [15:0] token_length;
      logic [3:0]  error_code;
      logic        last_of_run;
   } rsp_item_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0]                  count;
      rsp_item_type [MAX_RESULTS-1:0]         items;
   } step_out_type;

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= CHAR_ZERO) && (b < CHAR_COLONX);
   endfunction

   function automatic logic is_space(input logic [7:0] b);
      return (b == CHAR_SPACE) || (b == CHAR_NL) || (b == CHAR_TAB);
   endfunction

   // expected keyword byte at an offset of at most four
   function automatic logic [7:0] kw_char(input logic [1:0] sel, input logic [2:0] off);
      logic [7:0] c;
      c = 8'h00;
      case (sel)
         KW_TRUE: begin
            case (off)
               3'd0: c = 8'h74;
               3'd1: c = 8'h72;
               3'd2: c = 8'h75;
               3'd3: c = 8'h65;
               default: c = 8'h00;
            endcase
         end
         KW_FALSE: begin
            case (off)
               3'd0: c = 8'h66;
               3'd1: c = 8'h61;
               3'd2: c = 8'h6C;
               3'd3: c = 8'h73;
               default: c = 8'h65;
            endcase
         end
         default: begin
            case (off)
               3'd0: c = 8'h6E;
               3'd1: c = 8'h75;
               3'd2: c = 8'h6C;
               3'd3: c = 8'h6C;
               default: c = 8'h00;
            endcase
         end
      endcase
      return c;
   endfunction

   function automatic logic [2:0] kw_len(input logic [1:0] sel);
      return (sel == KW_FALSE) ? 3'd5 : 3'd4;
   endfunction

   function automatic logic [3:0] kw_type(input logic [1:0] sel);
      return (sel == KW_TRUE || sel == KW_FALSE) ? TOK_BOOLEAN : TOK_NULL;
   endfunction

endpackage

`default_nettype wire

// ----- design/jtl_if.sv -----
`default_nettype none

interface jtl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       end_of_buffer;

   modport source (output valid, output byte_value, output end_of_buffer, input ready);
   modport sink   (input valid, input byte_value, input end_of_buffer, output ready);
endinterface

interface jtl_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [3:0]  token_type;
   logic [15:0] start_position;
   logic [15:0] token_length;
   logic [3:0]  error_code;
   logic        last_of_run;

   modport source (output valid, output result_kind, output token_type,
                   output start_position, output token_length, output error_code,
                   output last_of_run, input ready);
   modport sink   (input valid, input result_kind, input token_type,
                   input start_position, input token_length, input error_code,
                   input last_of_run, output ready);
endinterface

`default_nettype wire

// ----- design/jtl_lex_step.sv -----
`default_nettype none

module jtl_lex_step #(
   parameter int POSITION_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  fire,
   input  wire logic [7:0]            byte_value,
   input  wire logic                  end_of_buffer,
   output jtl_pkg::step_out_type      step_out
);
   import jtl_pkg::*;

   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

   // lexer state
   logic [1:0]               mode_ff, mode_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS-1:0] tstart_ff, tstart_in;
   logic                     seen_dot_ff, seen_dot_in;
   logic                     esc_ff, esc_in;
   logic [1:0]               ksel_ff, ksel_in;
   logic [2:0]               koff_ff, koff_in;
   logic                     kmis_ff, kmis_in;
   logic                     err_latched_ff, err_latched_in;

   logic [COUNT_BITS-1:0]          n;
   rsp_item_type [MAX_RESULTS-1:0] res;
   logic                           err;
   logic [2:0]                     off;
   logic [31:0]                    pos_w, tstart_w, diff_w;

   function automatic rsp_item_type mk(input logic [1:0] kind, input logic [3:0] ttype,
                                       input logic [31:0] start, input logic [31:0] len,
                                       input logic [3:0] code);
      rsp_item_type r;
      r.result_kind    = kind;
      r.token_type     = ttype;
      r.start_position = start[15:0];
      r.token_length   = len[15:0];
      r.error_code     = code;
      r.last_of_run    = 1'b0;
      return r;
   endfunction

   assign pos_w    = 32'(pos_ff);
   assign tstart_w = 32'(tstart_ff);
   assign diff_w   = 32'(pos_ff - tstart_ff);
   assign off      = (koff_ff > 3'd4) ? 3'd4 : koff_ff;

   // one byte of lexing
   always_comb begin
      mode_in        = mode_ff;
      tstart_in      = tstart_ff;
      seen_dot_in    = seen_dot_ff;
      esc_in         = esc_ff;
      ksel_in        = ksel_ff;
      koff_in        = koff_ff;
      kmis_in        = kmis_ff;
      err_latched_in = err_latched_ff;
      pos_in         = pos_ff + 1'b1;
      n              = '0;
      res            = '0;
      err            = 1'b0;

      if (!err_latched_ff) begin
         if (pos_ff == POS_MAX && !end_of_buffer) begin
            res[n] = mk(KIND_ERROR, TOK_NONE, pos_w, 32'd0, ERR_TOO_LONG);
            n = n + 1'b1;
            err = 1'b1;
         end else begin
            unique case (mode_ff)
               MODE_NUMBER: begin
                  if (byte_value == CHAR_DOT) begin
                     if (seen_dot_ff) begin
                        res[n] = mk(KIND_ERROR, TOK_NONE, pos_w, 32'd0, ERR_TWO_DOTS);
                        n = n + 1'b1;
                        err = 1'b1;
                     end else begin
                        seen_dot_in = 1'b1;
                     end
                  end else if (byte_value == CHAR_MINUS) begin
                     res[n] = mk(KIND_ERROR, TOK_NONE, pos_w, 32'd0, ERR_INNER_MINUS);
                     n = n + 1'b1;
                     err = 1'b1;
                  end else if (is_space(byte_value) || byte_value == CHAR_COMMA ||
                               byte_value == CHAR_RBRACK || byte_value == CHAR_RBRACE) begin
                     res[n] = mk(KIND_TOKEN, seen_dot_ff ? TOK_REAL : TOK_INTEGER,
                                 tstart_w, diff_w, ERR_NONE);
                     n = n + 1'b1;
                     mode_in = MODE_IDLE;
                     // the terminator's own token
                     if (byte_value == CHAR_COMMA) begin
                        res[n] = mk(KIND_TOKEN, TOK_COMMA, pos_w, 32'd1, ERR_NONE);
                        n = n + 1'b1;
                     end else if (byte_value == CHAR_RBRACK) begin
                        res[n] = mk(KIND_TOKEN, TOK_RBRACK, pos_w, 32'd1, ERR_NONE);
                        n = n + 1'b1;
                     end else if (byte_value == CHAR_RBRACE) begin
                        res[n] = mk(KIND_TOKEN, TOK_RBRACE, pos_w, 32'd1, ERR_NONE);
                        n = n + 1'b1;
                     end
                  end else if (!is_digit(byte_value)) begin
                     res[n] = mk(KIND_ERROR, TOK_NONE, pos_w, 32'd0, ERR_BAD_NUMBER);
                     n = n + 1'b1;
                     err = 1'b1;
                  end
               end
               MODE_STRING: begin
                  if (byte_value == CHAR_BSLASH) begin
                     esc_in = !esc_ff;
                  end else begin
                     if (byte_value == CHAR_QUOTE && !esc_ff) begin
                        res[n] = mk(KIND_TOKEN, TOK_STRING, tstart_w, diff_w + 32'd1, ERR_NONE);
                        n = n + 1'b1;
                        mode_in = MODE_IDLE;
                     end
                     esc_in = 1'b0;
                  end
               end
               MODE_KEYWORD: begin
                  if (byte_value != kw_char(ksel_ff, off)) begin
                     kmis_in = 1'b1;
                  end
                  if (off + 3'd1 >= kw_len(ksel_ff)) begin
                     if (kmis_in) begin
                        res[n] = mk(KIND_ERROR, TOK_NONE, tstart_w, 32'd0, ERR_KW_MISMATCH);
                        n = n + 1'b1;
                        err = 1'b1;
                     end else begin
                        res[n] = mk(KIND_TOKEN, kw_type(ksel_ff), tstart_w,
                                    32'(kw_len(ksel_ff)), ERR_NONE);
                        n = n + 1'b1;
                     end
                     mode_in = MODE_IDLE;
                  end else begin
                     koff_in = off + 3'd1;
                  end
               end
               MODE_IDLE: begin
                  case (byte_value) inside
                     CHAR_LBRACE: begin
                        res[n] = mk(KIND_TOKEN, TOK_LBRACE, pos_w, 32'd1, ERR_NONE);
                        n = n + 1'b1;
                     end
                     CHAR_RBRACE: begin
                        res[n] = mk(KIND_TOKEN, TOK_RBRACE, pos_w, 32'd1, ERR_NONE);
                        n = n + 1'b1;
                     end
                     CHAR_LBRACK: begin
                        res[n] = mk(KIND_TOKEN, TOK_LBRACK, pos_w, 32'd1, ERR_NONE);
                        n = n + 1'b1;
                     end
                     CHAR_RBRACK: begin
                        res[n] = mk(KIND_TOKEN, TOK_RBRACK, pos_w, 32'd1, ERR_NONE);
                        n = n + 1'b1;
                     end
                     CHAR_COLON: begin
                        res[n] = mk(KIND_TOKEN, TOK_COLON, pos_w, 32'd1, ERR_NONE);
                        n = n + 1'b1;
                     end
                     CHAR_COMMA: begin
                        res[n] = mk(KIND_TOKEN, TOK_COMMA, pos_w, 32'd1, ERR_NONE);
                        n = n + 1'b1;
                     end
                     CHAR_QUOTE: begin
                        mode_in   = MODE_STRING;
                        tstart_in = pos_ff;
                        esc_in    = 1'b0;
                     end
                     CHAR_T, CHAR_F, CHAR_N: begin
                        mode_in   = MODE_KEYWORD;
                        tstart_in = pos_ff;
                        ksel_in   = (byte_value == CHAR_T) ? KW_TRUE :
                                    (byte_value == CHAR_F) ? KW_FALSE : KW_NULL;
                        koff_in   = 3'd1;
                        kmis_in   = 1'b0;
                     end
                     default: begin
                        if (is_digit(byte_value) || byte_value == CHAR_MINUS) begin
                           mode_in     = MODE_NUMBER;
                           tstart_in   = pos_ff;
                           seen_dot_in = 1'b0;
                        end else if (!is_space(byte_value)) begin
                           res[n] = mk(KIND_ERROR, TOK_NONE, pos_w, 32'd0, ERR_STRAY);
                           n = n + 1'b1;
                           err = 1'b1;
                        end
                     end
                  endcase
               end
               default: begin
                  mode_in = MODE_IDLE;
               end
            endcase
         end

         // end of buffer inside a token, or a clean finish
         if (!err && end_of_buffer && mode_in != MODE_IDLE) begin
            res[n] = mk(KIND_ERROR, TOK_NONE, pos_w, 32'd0,
                        (mode_in == MODE_NUMBER) ? ERR_END_NUMBER :
                        (mode_in == MODE_STRING) ? ERR_END_STRING : ERR_END_KEYWORD);
            n = n + 1'b1;
            err = 1'b1;
         end
         if (!err && end_of_buffer) begin
            res[n] = mk(KIND_DONE, TOK_NONE, 32'd0, 32'd0, ERR_NONE);
            n = n + 1'b1;
         end
         if (n != '0) begin
            res[n - 1'b1].last_of_run = 1'b1;
         end
         if (err) begin
            err_latched_in = 1'b1;
         end
      end

      // every buffer restarts at position zero
      if (end_of_buffer) begin
         mode_in        = MODE_IDLE;
         pos_in         = '0;
         tstart_in      = '0;
         seen_dot_in    = 1'b0;
         esc_in         = 1'b0;
         ksel_in        = KW_TRUE;
         koff_in        = 3'd0;
         kmis_in        = 1'b0;
         err_latched_in = 1'b0;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_IDLE;
         pos_ff         <= '0;
         tstart_ff      <= '0;
         seen_dot_ff    <= 1'b0;
         esc_ff         <= 1'b0;
         ksel_ff        <= KW_TRUE;
         koff_ff        <= 3'd0;
         kmis_ff        <= 1'b0;
         err_latched_ff <= 1'b0;
      end else if (fire) begin
         mode_ff        <= mode_in;
         pos_ff         <= pos_in;
         tstart_ff      <= tstart_in;
         seen_dot_ff    <= seen_dot_in;
         esc_ff         <= esc_in;
         ksel_ff        <= ksel_in;
         koff_ff        <= koff_in;
         kmis_ff        <= kmis_in;
         err_latched_ff <= err_latched_in;
      end
   end

   assign step_out.count = fire ? n : '0;
   assign step_out.items = res;

endmodule

`default_nettype wire

// ----- design/jtl_result_queue.sv -----
`default_nettype none

module jtl_result_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire jtl_pkg::step_out_type push,
   output logic                       has_room,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output jtl_pkg::rsp_item_type      out_item
);
   import jtl_pkg::*;

   rsp_item_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_BITS-1:0]   count_ff, count_in;
   logic                     pop;

   assign out_valid = (count_ff != '0);
   assign out_item  = entry_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;
   assign has_room  = (count_ff <= QCOUNT_BITS'(QUEUE_DEPTH - MAX_RESULTS));

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_BITS'(push.count);
      rd_ptr_in = rd_ptr_ff + QPTR_BITS'(pop);
      count_in  = count_ff + QCOUNT_BITS'(push.count) - QCOUNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // up to three results written per cycle
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         if (COUNT_BITS'(i) < push.count) begin
            entry_ff[wr_ptr_ff + QPTR_BITS'(i)] <= push.items[i];
         end
      end
   end

endmodule

`default_nettype wire

// ----- design/json_token_lexer.sv -----
// Streaming JSON lexer. Each request carries one buffer byte and an end-of-buffer
// flag; responses are tokens (type, start, length), one error per faulty buffer
// (after which the rest of that buffer is swallowed) or a done marker for a clean
// buffer, with last_of_run set on the final response that a byte causes. A byte
// is taken every cycle as long as each byte yields at most one response and the
// response port is not stalled; a byte that yields two or three responses (a
// number closed by a bracket or comma, followed by the end of the buffer) keeps
// the response port busy with them; bytes stall while the four-entry response
// queue behind a one-byte input register lacks room. A byte is held in the input
// register, and its responses in the queue. Positions count from zero within each
// buffer over POSITION_BITS bits and are reported in 16 bits.
`default_nettype none

module json_token_lexer #(
   parameter int POSITION_BITS = 16
) (
   input  wire logic   clock,
   input  wire logic   reset,
   jtl_req_if.sink     req_bus,
   jtl_rsp_if.source   rsp_bus
);
   import jtl_pkg::*;

   logic         stage_valid_ff, stage_valid_in;
   logic [7:0]   byte_ff;
   logic         eob_ff;
   logic         has_room;
   logic         advance;
   logic         take;
   step_out_type step_out;
   rsp_item_type head;

   // input register
   assign advance        = stage_valid_ff && has_room;
   assign req_bus.ready  = !stage_valid_ff || advance;
   assign take           = req_bus.valid && req_bus.ready;
   assign stage_valid_in = take || (stage_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff <= req_bus.byte_value;
         eob_ff  <= req_bus.end_of_buffer;
      end
   end

   jtl_lex_step #(
      .POSITION_BITS (POSITION_BITS)
   ) u_step (
      .clock         (clock),
      .reset         (reset),
      .fire          (advance),
      .byte_value    (byte_ff),
      .end_of_buffer (eob_ff),
      .step_out      (step_out)
   );

   jtl_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (step_out),
      .has_room  (has_room),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_item  (head)
   );

   // response payload
   assign rsp_bus.result_kind    = head.result_kind;
   assign rsp_bus.token_type     = head.token_type;
   assign rsp_bus.start_position = head.start_position;
   assign rsp_bus.token_length   = head.token_length;
   assign rsp_bus.error_code     = head.error_code;
   assign rsp_bus.last_of_run    = head.last_of_run;

endmodule

`default_nettype wire

// ----- design/jtl_checker.sv -----
`default_nettype none

module jtl_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_result_kind,
   input wire logic [3:0]  rsp_token_type,
   input wire logic [15:0] rsp_start_position,
   input wire logic [15:0] rsp_token_length,
   input wire logic [3:0]  rsp_error_code,
   input wire logic        rsp_last_of_run
);
   import jtl_pkg::*;

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_kind) &&
      $stable(rsp_token_type) && $stable(rsp_start_position) &&
      $stable(rsp_token_length) && $stable(rsp_error_code) && $stable(rsp_last_of_run))
      else $error("response changed while stalled");

   // no response straight after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // kind is one of token, error, done
   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_result_kind == KIND_TOKEN || rsp_result_kind == KIND_ERROR ||
                     rsp_result_kind == KIND_DONE))
      else $error("illegal result kind");

   // an error carries no token type and no length
   a_error_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_ERROR |->
      rsp_token_type == TOK_NONE && rsp_token_length == 16'd0)
      else $error("error response with token fields");

   // done always closes the run for its byte
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_DONE |->
      rsp_last_of_run && rsp_error_code == ERR_NONE && rsp_start_position == 16'd0)
      else $error("done response malformed");

endmodule

bind json_token_lexer jtl_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .rsp_result_kind    (rsp_bus.result_kind),
   .rsp_token_type     (rsp_bus.token_type),
   .rsp_start_position (rsp_bus.start_position),
   .rsp_token_length   (rsp_bus.token_length),
   .rsp_error_code     (rsp_bus.error_code),
   .rsp_last_of_run    (rsp_bus.last_of_run)
);

`default_nettype wire
